// ===== rtl/spi_nor_flash_command_sequencer_macros.svh =====
// assertion macros shared by the command sequencer modules
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH

// property checked at every clock edge outside reset
`define SNFCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define SNFCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  `SNFCS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/snfcs_pkg.sv =====
// types, opcodes and sizes for the serial nor flash command sequencer
`timescale 1ns / 1ps
package snfcs_pkg;

  localparam int unsigned SECTOR_BYTES      = 4096;
  localparam int unsigned SECTORS_PER_BLOCK = 16;
  localparam int unsigned BLOCK_BYTES       = SECTOR_BYTES * SECTORS_PER_BLOCK;

  localparam logic [31:0] SECTOR_MUL = 32'(SECTOR_BYTES);
  localparam logic [31:0] BLOCK_MUL  = 32'(BLOCK_BYTES);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] OPC_READ_ID    = 8'h9F;
  localparam logic [7:0] OPC_RDSR1      = 8'h05;
  localparam logic [7:0] OPC_RDSR2      = 8'h35;
  localparam logic [7:0] OPC_RDSR3      = 8'h15;
  localparam logic [7:0] OPC_WRSR1      = 8'h01;
  localparam logic [7:0] OPC_WRSR2      = 8'h31;
  localparam logic [7:0] OPC_WRSR3      = 8'h11;
  localparam logic [7:0] OPC_WREN       = 8'h06;
  localparam logic [7:0] OPC_WRDI       = 8'h04;
  localparam logic [7:0] OPC_CHIP_ERASE = 8'hC7;
  localparam logic [7:0] OPC_SECTOR_ER  = 8'h20;
  localparam logic [7:0] OPC_BLOCK_ER   = 8'hD8;
  localparam logic [7:0] OPC_PROGRAM    = 8'h02;
  localparam logic [7:0] OPC_FAST_READ  = 8'h0B;
  localparam logic [7:0] DUMMY_BYTE     = 8'hA5;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_RECEIVE = 1'b1
  } operation_e;

  typedef enum logic [3:0] {
    CMD_READ_ID      = 4'd0,
    CMD_READ_STATUS  = 4'd1,
    CMD_WRITE_STATUS = 4'd2,
    CMD_WRITE_ENABLE = 4'd3,
    CMD_WRITE_DISABLE = 4'd4,
    CMD_CHIP_ERASE   = 4'd5,
    CMD_SECTOR_ERASE = 4'd6,
    CMD_BLOCK_ERASE  = 4'd7,
    CMD_PROGRAM      = 4'd8,
    CMD_READ         = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_RESULT  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    JOB_ID,
    JOB_RDSR,
    JOB_WRSR,
    JOB_SIMPLE,
    JOB_CHIP,
    JOB_POLL,
    JOB_READ,
    JOB_FINISH,
    JOB_DUMMY,
    JOB_WRITE
  } job_e;

  typedef struct packed {
    logic        operation;
    logic [3:0]  command;
    logic [1:0]  status_select;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  spi_byte;
    logic        capture;
    logic [23:0] result_value;
    logic        last;
  } out_item_t;

  typedef struct packed {
    job_e        kind;
    logic [7:0]  opcode;
    logic [7:0]  data;
    logic [23:0] value;
    logic [31:0] address;
    logic        with_data;
  } job_t;

endpackage

// ===== rtl/snfcs_queue.sv =====
// short job queue between the classifying front and the byte sequencer
`timescale 1ns / 1ps
`include "spi_nor_flash_command_sequencer_macros.svh"
module snfcs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  snfcs_pkg::job_t   push_job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output snfcs_pkg::job_t   head_job_o
);

  snfcs_pkg::job_t                  entries_q [snfcs_pkg::QDEPTH];
  logic [snfcs_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [snfcs_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [snfcs_pkg::QCNT_W-1:0]     count_q, count_d;

  assign head_valid_o = count_q != '0;
  assign full_o       = count_q == snfcs_pkg::QCNT_W'(snfcs_pkg::QDEPTH);
  assign head_job_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == snfcs_pkg::QPTR_W'(snfcs_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_q + snfcs_pkg::QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == snfcs_pkg::QPTR_W'(snfcs_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_q + snfcs_pkg::QPTR_W'(1);
    end
    count_d = count_q + snfcs_pkg::QCNT_W'(push_i) - snfcs_pkg::QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

  `SNFCS_ASSERT(q_no_overflow, push_i |-> !full_o, "job pushed into a full queue")
  `SNFCS_ASSERT(q_no_underflow, pop_i |-> head_valid_o, "job popped from an empty queue")
  `SNFCS_ASSERT(q_count_bound, count_q <= snfcs_pkg::QCNT_W'(snfcs_pkg::QDEPTH),
                "queue count out of range")

endmodule

// ===== rtl/snfcs_front.sv =====
// front end: takes input items, tracks the transaction phase, emits jobs
`timescale 1ns / 1ps
module snfcs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  snfcs_pkg::in_item_t  in_item_i,
  input  logic                 queue_full_i,
  output logic                 job_valid_o,
  output snfcs_pkg::job_t      job_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ID,
    PH_RDSR,
    PH_PRE,
    PH_POST,
    PH_READ
  } phase_e;

  phase_e               phase_q, phase_d;
  snfcs_pkg::cmd_e      pending_q, pending_d;
  logic [31:0]          addr_q, addr_d;
  logic [7:0]           data_q, data_d;
  logic [1:0]           count_q, count_d;
  logic [23:0]          id_q, id_d;
  logic                 accept;
  logic [1:0]           sel_idx;
  logic [23:0]          id_next;
  logic [7:0]           write_opc;

  assign accept  = in_valid_i && !queue_full_i;
  assign id_next = {id_q[15:0], in_item_i.rx_byte};

  always_comb begin
    unique case (in_item_i.status_select)
      2'd1:    sel_idx = 2'd0;
      2'd2:    sel_idx = 2'd1;
      default: sel_idx = 2'd2;
    endcase
  end

  always_comb begin
    priority if (pending_q == snfcs_pkg::CMD_SECTOR_ERASE) begin
      write_opc = snfcs_pkg::OPC_SECTOR_ER;
    end else if (pending_q == snfcs_pkg::CMD_BLOCK_ERASE) begin
      write_opc = snfcs_pkg::OPC_BLOCK_ER;
    end else begin
      write_opc = snfcs_pkg::OPC_PROGRAM;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    addr_d    = addr_q;
    data_d    = data_q;
    count_d   = count_q;
    id_d      = id_q;
    job_valid_o       = 1'b0;
    job_o.kind        = snfcs_pkg::JOB_FINISH;
    job_o.opcode      = '0;
    job_o.data        = '0;
    job_o.value       = '0;
    job_o.address     = '0;
    job_o.with_data   = 1'b0;
    if (accept) begin
      if (in_item_i.operation == snfcs_pkg::OP_RECEIVE) begin
        unique case (phase_q)
          PH_ID: begin
            id_d    = id_next;
            count_d = count_q + 2'd1;
            if (count_q == 2'd2) begin
              count_d     = '0;
              phase_d     = PH_IDLE;
              job_valid_o = 1'b1;
              job_o.kind  = snfcs_pkg::JOB_FINISH;
              job_o.value = id_next;
            end
          end
          PH_RDSR, PH_READ: begin
            phase_d     = PH_IDLE;
            job_valid_o = 1'b1;
            job_o.kind  = snfcs_pkg::JOB_FINISH;
            job_o.value = {16'd0, in_item_i.rx_byte};
          end
          PH_PRE, PH_POST: begin
            job_valid_o = 1'b1;
            if (in_item_i.rx_byte[0]) begin
              job_o.kind = snfcs_pkg::JOB_DUMMY;
            end else if (phase_q == PH_PRE) begin
              phase_d         = PH_POST;
              job_o.kind      = snfcs_pkg::JOB_WRITE;
              job_o.opcode    = write_opc;
              job_o.address   = addr_q;
              job_o.data      = data_q;
              job_o.with_data = pending_q == snfcs_pkg::CMD_PROGRAM;
            end else begin
              phase_d    = PH_IDLE;
              job_o.kind = snfcs_pkg::JOB_FINISH;
            end
          end
          default: begin
          end
        endcase
      end else if (phase_q == PH_IDLE) begin
        unique case (snfcs_pkg::cmd_e'(in_item_i.command))
          snfcs_pkg::CMD_READ_ID: begin
            id_d         = '0;
            phase_d      = PH_ID;
            job_valid_o  = 1'b1;
            job_o.kind   = snfcs_pkg::JOB_ID;
            job_o.opcode = snfcs_pkg::OPC_READ_ID;
          end
          snfcs_pkg::CMD_READ_STATUS: begin
            phase_d      = PH_RDSR;
            job_valid_o  = 1'b1;
            job_o.kind   = snfcs_pkg::JOB_RDSR;
            unique case (sel_idx)
              2'd0:    job_o.opcode = snfcs_pkg::OPC_RDSR1;
              2'd1:    job_o.opcode = snfcs_pkg::OPC_RDSR2;
              default: job_o.opcode = snfcs_pkg::OPC_RDSR3;
            endcase
          end
          snfcs_pkg::CMD_WRITE_STATUS: begin
            data_d          = in_item_i.data_byte;
            job_valid_o     = 1'b1;
            job_o.kind      = snfcs_pkg::JOB_WRSR;
            job_o.data      = in_item_i.data_byte;
            job_o.with_data = 1'b1;
            unique case (sel_idx)
              2'd0:    job_o.opcode = snfcs_pkg::OPC_WRSR1;
              2'd1:    job_o.opcode = snfcs_pkg::OPC_WRSR2;
              default: job_o.opcode = snfcs_pkg::OPC_WRSR3;
            endcase
          end
          snfcs_pkg::CMD_WRITE_ENABLE, snfcs_pkg::CMD_WRITE_DISABLE: begin
            job_valid_o  = 1'b1;
            job_o.kind   = snfcs_pkg::JOB_SIMPLE;
            job_o.opcode = (in_item_i.command == snfcs_pkg::CMD_WRITE_ENABLE)
                           ? snfcs_pkg::OPC_WREN : snfcs_pkg::OPC_WRDI;
          end
          snfcs_pkg::CMD_CHIP_ERASE: begin
            phase_d      = PH_POST;
            job_valid_o  = 1'b1;
            job_o.kind   = snfcs_pkg::JOB_CHIP;
            job_o.opcode = snfcs_pkg::OPC_CHIP_ERASE;
          end
          snfcs_pkg::CMD_SECTOR_ERASE, snfcs_pkg::CMD_BLOCK_ERASE,
          snfcs_pkg::CMD_PROGRAM: begin
            unique case (snfcs_pkg::cmd_e'(in_item_i.command))
              snfcs_pkg::CMD_SECTOR_ERASE: addr_d = in_item_i.address * snfcs_pkg::SECTOR_MUL;
              snfcs_pkg::CMD_BLOCK_ERASE:  addr_d = in_item_i.address * snfcs_pkg::BLOCK_MUL;
              default:                     addr_d = in_item_i.address;
            endcase
            data_d      = in_item_i.data_byte;
            phase_d     = PH_PRE;
            job_valid_o = 1'b1;
            job_o.kind  = snfcs_pkg::JOB_POLL;
          end
          snfcs_pkg::CMD_READ: begin
            addr_d        = in_item_i.address;
            phase_d       = PH_READ;
            job_valid_o   = 1'b1;
            job_o.kind    = snfcs_pkg::JOB_READ;
            job_o.opcode  = snfcs_pkg::OPC_FAST_READ;
            job_o.address = in_item_i.address;
          end
          default: begin
          end
        endcase
        if (in_item_i.command <= snfcs_pkg::CMD_READ) begin
          pending_d = snfcs_pkg::cmd_e'(in_item_i.command);
          count_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pending_q <= snfcs_pkg::CMD_READ_ID;
      addr_q    <= '0;
      data_q    <= '0;
      count_q   <= '0;
      id_q      <= '0;
    end else begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
      addr_q    <= addr_d;
      data_q    <= data_d;
      count_q   <= count_d;
      id_q      <= id_d;
    end
  end

endmodule

// ===== rtl/snfcs_back.sv =====
// back end: expands queued jobs into spi bytes, releases and host results
`timescale 1ns / 1ps
`include "spi_nor_flash_command_sequencer_macros.svh"
module snfcs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  head_valid_i,
  input  snfcs_pkg::job_t       head_job_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output snfcs_pkg::out_item_t  out_item_o
);

  typedef enum logic [3:0] {
    UOP_OPC,
    UOP_WREN,
    UOP_RDSR1,
    UOP_ZERO,
    UOP_DUM,
    UOP_A3,
    UOP_A2,
    UOP_A1,
    UOP_A0,
    UOP_DATA,
    UOP_REL,
    UOP_RES,
    UOP_END
  } uop_e;

  function automatic uop_e seq_op(snfcs_pkg::job_e k, logic [3:0] i);
    uop_e op;
    op = UOP_END;
    unique case (k)
      snfcs_pkg::JOB_ID: begin
        unique case (i)
          4'd0:             op = UOP_OPC;
          4'd1, 4'd2, 4'd3: op = UOP_DUM;
          default:          op = UOP_END;
        endcase
      end
      snfcs_pkg::JOB_RDSR: begin
        unique case (i)
          4'd0:    op = UOP_OPC;
          4'd1:    op = UOP_DUM;
          default: op = UOP_END;
        endcase
      end
      snfcs_pkg::JOB_WRSR: begin
        unique case (i)
          4'd0:    op = UOP_OPC;
          4'd1:    op = UOP_DATA;
          4'd2:    op = UOP_REL;
          4'd3:    op = UOP_RES;
          default: op = UOP_END;
        endcase
      end
      snfcs_pkg::JOB_SIMPLE: begin
        unique case (i)
          4'd0:    op = UOP_OPC;
          4'd1:    op = UOP_REL;
          4'd2:    op = UOP_RES;
          default: op = UOP_END;
        endcase
      end
      snfcs_pkg::JOB_CHIP: begin
        unique case (i)
          4'd0:       op = UOP_WREN;
          4'd1, 4'd3: op = UOP_REL;
          4'd2:       op = UOP_OPC;
          4'd4:       op = UOP_RDSR1;
          4'd5:       op = UOP_DUM;
          default:    op = UOP_END;
        endcase
      end
      snfcs_pkg::JOB_POLL: begin
        unique case (i)
          4'd0:    op = UOP_RDSR1;
          4'd1:    op = UOP_DUM;
          default: op = UOP_END;
        endcase
      end
      snfcs_pkg::JOB_READ: begin
        unique case (i)
          4'd0:    op = UOP_OPC;
          4'd1:    op = UOP_A3;
          4'd2:    op = UOP_A2;
          4'd3:    op = UOP_A1;
          4'd4:    op = UOP_A0;
          4'd5:    op = UOP_ZERO;
          4'd6:    op = UOP_DUM;
          default: op = UOP_END;
        endcase
      end
      snfcs_pkg::JOB_FINISH: begin
        unique case (i)
          4'd0:    op = UOP_REL;
          4'd1:    op = UOP_RES;
          default: op = UOP_END;
        endcase
      end
      snfcs_pkg::JOB_DUMMY: begin
        unique case (i)
          4'd0:    op = UOP_DUM;
          default: op = UOP_END;
        endcase
      end
      snfcs_pkg::JOB_WRITE: begin
        unique case (i)
          4'd0, 4'd2, 4'd9: op = UOP_REL;
          4'd1:             op = UOP_WREN;
          4'd3:             op = UOP_OPC;
          4'd4:             op = UOP_A3;
          4'd5:             op = UOP_A2;
          4'd6:             op = UOP_A1;
          4'd7:             op = UOP_A0;
          4'd8:             op = UOP_DATA;
          4'd10:            op = UOP_RDSR1;
          4'd11:            op = UOP_DUM;
          default:          op = UOP_END;
        endcase
      end
      default: op = UOP_END;
    endcase
    return op;
  endfunction

  logic                  four_byte_q;
  logic [3:0]            idx_q;
  logic                  out_valid_q;
  snfcs_pkg::out_item_t  out_q, out_d;
  uop_e                  cur_op, op_p1, op_p2, next_op;
  logic                  skip_p1;
  logic [3:0]            next_idx;
  logic                  emit;
  logic                  last;

  assign cur_op  = seq_op(head_job_i.kind, idx_q);
  assign op_p1   = seq_op(head_job_i.kind, idx_q + 4'd1);
  assign op_p2   = seq_op(head_job_i.kind, idx_q + 4'd2);
  assign skip_p1 = (op_p1 == UOP_A3 && !four_byte_q)
                || (op_p1 == UOP_DATA && !head_job_i.with_data);
  assign next_op  = skip_p1 ? op_p2 : op_p1;
  assign next_idx = skip_p1 ? idx_q + 4'd2 : idx_q + 4'd1;
  assign last     = next_op == UOP_END;
  assign emit     = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o    = emit && last;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    out_d.kind         = snfcs_pkg::KIND_SEND;
    out_d.spi_byte     = '0;
    out_d.capture      = 1'b0;
    out_d.result_value = '0;
    out_d.last         = last;
    unique case (cur_op)
      UOP_OPC:   out_d.spi_byte = head_job_i.opcode;
      UOP_WREN:  out_d.spi_byte = snfcs_pkg::OPC_WREN;
      UOP_RDSR1: out_d.spi_byte = snfcs_pkg::OPC_RDSR1;
      UOP_ZERO:  out_d.spi_byte = '0;
      UOP_DUM: begin
        out_d.spi_byte = snfcs_pkg::DUMMY_BYTE;
        out_d.capture  = 1'b1;
      end
      UOP_A3:    out_d.spi_byte = head_job_i.address[31:24];
      UOP_A2:    out_d.spi_byte = head_job_i.address[23:16];
      UOP_A1:    out_d.spi_byte = head_job_i.address[15:8];
      UOP_A0:    out_d.spi_byte = head_job_i.address[7:0];
      UOP_DATA:  out_d.spi_byte = head_job_i.data;
      UOP_REL:   out_d.kind = snfcs_pkg::KIND_RELEASE;
      UOP_RES: begin
        out_d.kind         = snfcs_pkg::KIND_RESULT;
        out_d.result_value = head_job_i.value;
      end
      default:   out_d.kind = snfcs_pkg::KIND_SEND;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_byte_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        four_byte_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? 4'd0 : next_idx;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  `SNFCS_ASSERT(bk_no_end_emit, head_valid_i |-> cur_op != UOP_END,
                "sequencer points past the end of its job")
  `SNFCS_ASSERT(bk_drop_on_take, $fell(out_valid_q) |-> $past(!out_stall_i),
                "held transfer dropped while stalled")
  `SNFCS_ASSERT_NEXT(bk_idx_hold, head_valid_i && !emit, $stable(idx_q),
                     "step index moved without a transfer")

endmodule

// ===== rtl/spi_nor_flash_command_sequencer.sv =====
// top level of the serial nor flash command sequencer
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  in_item_i  (snfcs_pkg::in_item_t)
//   out      output     out_valid_o / out_stall_i out_item_o (snfcs_pkg::out_item_t)
//   cfg      input      cfg_we_i                cfg_wdata_i (four byte address)
//
// an input transfer is taken while the job queue has room
// each job yields one output transfer per cycle when not stalled, 0 to 12 per item
// an item's first output transfer passes the job queue and the output register
// the back end output register keeps the out side moving independent of the in side
// in_stall_o rises only when the two-entry job queue is full
// reset clears phase, queue and output valid; no clearing pass
`timescale 1ns / 1ps
module spi_nor_flash_command_sequencer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  snfcs_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output snfcs_pkg::out_item_t  out_item_o
);

  logic             q_full;
  logic             job_valid;
  snfcs_pkg::job_t  job;
  logic             head_valid;
  snfcs_pkg::job_t  head_job;
  logic             pop;

  assign in_stall_o = q_full;

  snfcs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .queue_full_i (q_full),
    .job_valid_o  (job_valid),
    .job_o        (job)
  );

  snfcs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (job_valid),
    .push_job_i   (job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  snfcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the serial nor flash command sequencer
`timescale 1ns / 1ps
module testbench;
  import snfcs_pkg::*;

  localparam int CLK_HALF  = 10;
  localparam int RESET_CYC = 11;
  localparam int LIMIT     = 400000;
  localparam int SETTLE    = 24;
  localparam int HOLD_CYC  = 400;

  localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  class flash_scoreboard;
    typedef enum logic [2:0] {
      SEQ_IDLE, SEQ_ID, SEQ_STATUS, SEQ_WAIT_READY, SEQ_WAIT_DONE, SEQ_READ
    } seq_e;

    seq_e        seq;
    logic        four_byte;
    logic [3:0]  pending_cmd;
    logic [31:0] target_addr;
    logic [7:0]  held_data;
    logic [1:0]  id_count;
    logic [23:0] id_value;
    out_item_t   expected_q[$];
    out_item_t   burst_q[$];
    int          errors;

    function new();
      seq         = SEQ_IDLE;
      four_byte   = 1'b0;
      pending_cmd = '0;
      target_addr = '0;
      held_data   = '0;
      id_count    = '0;
      id_value    = '0;
      errors      = 0;
    endfunction

    function bit idle();
      return seq == SEQ_IDLE;
    endfunction

    function bit polling();
      return seq == SEQ_WAIT_READY || seq == SEQ_WAIT_DONE;
    endfunction

    function void emit(kind_e k, logic [7:0] b, logic cap, logic [23:0] v);
      out_item_t r;
      r.kind         = k;
      r.spi_byte     = b;
      r.capture      = cap;
      r.result_value = v;
      r.last         = 1'b0;
      burst_q.push_back(r);
    endfunction

    function void send_addr(logic [31:0] a);
      if (four_byte) emit(KIND_SEND, a[31:24], 1'b0, '0);
      emit(KIND_SEND, a[23:16], 1'b0, '0);
      emit(KIND_SEND, a[15:8], 1'b0, '0);
      emit(KIND_SEND, a[7:0], 1'b0, '0);
    endfunction

    function void start_poll();
      emit(KIND_SEND, OPC_RDSR1, 1'b0, '0);
      emit(KIND_SEND, DUMMY_BYTE, 1'b1, '0);
    endfunction

    function void finish_with(logic [23:0] v);
      emit(KIND_RELEASE, '0, 1'b0, '0);
      emit(KIND_RESULT, '0, 1'b0, v);
      seq = SEQ_IDLE;
    endfunction

    function void note_input(in_item_t it);
      logic [1:0] sel;
      logic [7:0] opcode;
      out_item_t  r;
      burst_q.delete();
      sel = (it.status_select == 2'd1) ? 2'd0 : (it.status_select == 2'd2) ? 2'd1 : 2'd2;
      if (it.operation == OP_RECEIVE) begin
        case (seq)
          SEQ_ID: begin
            id_value = {id_value[15:0], it.rx_byte};
            id_count++;
            if (id_count == 2'd3) begin
              id_count = '0;
              finish_with(id_value);
            end
          end
          SEQ_STATUS, SEQ_READ: begin
            finish_with({16'd0, it.rx_byte});
          end
          SEQ_WAIT_READY, SEQ_WAIT_DONE: begin
            if (it.rx_byte[0]) begin
              emit(KIND_SEND, DUMMY_BYTE, 1'b1, '0);
            end else if (seq == SEQ_WAIT_READY) begin
              opcode = (pending_cmd == CMD_SECTOR_ERASE) ? OPC_SECTOR_ER :
                       (pending_cmd == CMD_BLOCK_ERASE) ? OPC_BLOCK_ER : OPC_PROGRAM;
              emit(KIND_RELEASE, '0, 1'b0, '0);
              emit(KIND_SEND, OPC_WREN, 1'b0, '0);
              emit(KIND_RELEASE, '0, 1'b0, '0);
              emit(KIND_SEND, opcode, 1'b0, '0);
              send_addr(target_addr);
              if (pending_cmd == CMD_PROGRAM) emit(KIND_SEND, held_data, 1'b0, '0);
              emit(KIND_RELEASE, '0, 1'b0, '0);
              start_poll();
              seq = SEQ_WAIT_DONE;
            end else begin
              finish_with('0);
            end
          end
          default: ;
        endcase
      end else if (seq == SEQ_IDLE && it.command <= CMD_READ) begin
        pending_cmd = it.command;
        id_count    = '0;
        case (it.command)
          CMD_READ_ID: begin
            id_value = '0;
            emit(KIND_SEND, OPC_READ_ID, 1'b0, '0);
            repeat (3) emit(KIND_SEND, DUMMY_BYTE, 1'b1, '0);
            seq = SEQ_ID;
          end
          CMD_READ_STATUS: begin
            opcode = (sel == 2'd0) ? OPC_RDSR1 : (sel == 2'd1) ? OPC_RDSR2 : OPC_RDSR3;
            emit(KIND_SEND, opcode, 1'b0, '0);
            emit(KIND_SEND, DUMMY_BYTE, 1'b1, '0);
            seq = SEQ_STATUS;
          end
          CMD_WRITE_STATUS: begin
            opcode = (sel == 2'd0) ? OPC_WRSR1 : (sel == 2'd1) ? OPC_WRSR2 : OPC_WRSR3;
            emit(KIND_SEND, opcode, 1'b0, '0);
            emit(KIND_SEND, it.data_byte, 1'b0, '0);
            finish_with('0);
          end
          CMD_WRITE_ENABLE, CMD_WRITE_DISABLE: begin
            emit(KIND_SEND, (it.command == CMD_WRITE_ENABLE) ? OPC_WREN : OPC_WRDI, 1'b0, '0);
            finish_with('0);
          end
          CMD_CHIP_ERASE: begin
            emit(KIND_SEND, OPC_WREN, 1'b0, '0);
            emit(KIND_RELEASE, '0, 1'b0, '0);
            emit(KIND_SEND, OPC_CHIP_ERASE, 1'b0, '0);
            emit(KIND_RELEASE, '0, 1'b0, '0);
            start_poll();
            seq = SEQ_WAIT_DONE;
          end
          CMD_SECTOR_ERASE, CMD_BLOCK_ERASE, CMD_PROGRAM: begin
            if (it.command == CMD_SECTOR_ERASE) target_addr = it.address * SECTOR_MUL;
            else if (it.command == CMD_BLOCK_ERASE) target_addr = it.address * BLOCK_MUL;
            else target_addr = it.address;
            held_data = it.data_byte;
            start_poll();
            seq = SEQ_WAIT_READY;
          end
          default: begin
            emit(KIND_SEND, OPC_FAST_READ, 1'b0, '0);
            send_addr(it.address);
            emit(KIND_SEND, 8'h00, 1'b0, '0);
            emit(KIND_SEND, DUMMY_BYTE, 1'b1, '0);
            seq = SEQ_READ;
          end
        endcase
      end
      if (burst_q.size() > 0) begin
        r = burst_q.pop_back();
        r.last = 1'b1;
        burst_q.push_back(r);
        foreach (burst_q[i]) expected_q.push_back(burst_q[i]);
      end
    endfunction

    task report(string what, logic [35:0] got, logic [35:0] want);
      errors++;
      if (errors <= 40) $display("%0t mismatch in %s: got %0h, expected %0h",
                                 $realtime, what, got, want);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report("transfer with nothing expected", got, '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind) report("kind", got.kind, want.kind);
      if (got.spi_byte !== want.spi_byte) report("spi_byte", got.spi_byte, want.spi_byte);
      if (got.capture !== want.capture) report("capture", got.capture, want.capture);
      if (got.result_value !== want.result_value)
        report("result_value", got.result_value, want.result_value);
      if (got.last !== want.last) report("last", got.last, want.last);
    endtask
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_we_i;
  logic      cfg_wdata_i;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  logic            hold_on;
  int              sender_gap_pct;
  int              sink_stall_pct;
  int              tick_cnt = 0;
  flash_scoreboard sb;

  spi_nor_flash_command_sequencer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    tick_cnt <= tick_cnt + 1;
    if (tick_cnt > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    out_stall_i <= hold_on || ($urandom_range(99) < sink_stall_pct);
  end

  function automatic in_item_t request_item(logic [3:0] cmd, logic [1:0] sel,
                                            logic [31:0] addr, logic [7:0] data);
    in_item_t it;
    it               = '0;
    it.operation     = OP_REQUEST;
    it.command       = cmd;
    it.status_select = sel;
    it.address       = addr;
    it.data_byte     = data;
    return it;
  endfunction

  function automatic in_item_t receive_item(logic [7:0] b);
    in_item_t it;
    it           = '0;
    it.operation = OP_RECEIVE;
    it.rx_byte   = b;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       roll;
    roll             = $urandom_range(99);
    it.operation     = OP_REQUEST;
    it.command       = 4'($urandom_range(int'(CMD_READ)));
    it.status_select = 2'($urandom_range(3));
    it.address       = $urandom();
    it.data_byte     = 8'($urandom_range(255));
    it.rx_byte       = 8'($urandom_range(255));
    if (sb.idle()) begin
      if (roll < 6) begin
        it.operation = OP_RECEIVE;
      end else if (roll < 11) begin
        it.command = 4'($urandom_range(int'(CMD_UNUSED_HI), int'(CMD_UNUSED_LO)));
      end
    end else if (roll < 8) begin
      // request while a transfer sequence is open
      it.command = 4'($urandom_range(int'(CMD_UNUSED_HI)));
    end else begin
      it.operation = OP_RECEIVE;
      if (sb.polling()) it.rx_byte[0] = ($urandom_range(99) < 35);
    end
    return it;
  endfunction

  task automatic drive_item(in_item_t it);
    if ($urandom_range(99) < sender_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_gap_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_config(logic four_byte);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= four_byte;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    sb.four_byte = four_byte;
  endtask

  task automatic run_directed();
    in_item_t plan[$];
    plan.push_back(request_item(CMD_READ_ID, 2'd1, '0, '0));
    plan.push_back(receive_item(8'h00));
    plan.push_back(receive_item(8'hFF));
    plan.push_back(receive_item(8'h5A));
    // select zero maps to status register 3
    plan.push_back(request_item(CMD_READ_STATUS, 2'd0, '0, '0));
    plan.push_back(receive_item(8'hFF));
    plan.push_back(request_item(CMD_WRITE_STATUS, 2'd3, 32'hFFFF_FFFF, 8'hFF));
    plan.push_back(request_item(CMD_WRITE_ENABLE, 2'd2, '0, '0));
    plan.push_back(request_item(CMD_WRITE_DISABLE, 2'd1, '0, '0));
    plan.push_back(request_item(CMD_CHIP_ERASE, 2'd1, '0, '0));
    plan.push_back(receive_item(8'h01));
    plan.push_back(receive_item(8'h00));
    plan.push_back(request_item(CMD_SECTOR_ERASE, 2'd1, 32'hFFFF_FFFF, 8'h00));
    plan.push_back(receive_item(8'hFE));
    plan.push_back(receive_item(8'h00));
    plan.push_back(request_item(CMD_BLOCK_ERASE, 2'd2, 32'h0000_0001, 8'h3C));
    plan.push_back(receive_item(8'hFF));
    plan.push_back(receive_item(8'h00));
    plan.push_back(receive_item(8'h80));
    plan.push_back(request_item(CMD_PROGRAM, 2'd3, 32'hFFFF_FFFF, 8'hFF));
    plan.push_back(receive_item(8'h00));
    plan.push_back(receive_item(8'h00));
    // stray byte while idle and an unused command
    plan.push_back(receive_item(8'hFF));
    plan.push_back(request_item(CMD_UNUSED_HI, 2'd3, 32'hFFFF_FFFF, 8'hFF));
    plan.push_back(request_item(CMD_READ, 2'd1, '0, '0));
    plan.push_back(request_item(CMD_WRITE_ENABLE, 2'd1, '0, '0));
    plan.push_back(receive_item(8'h7E));
    foreach (plan[i]) drive_item(plan[i]);
  endtask

  task automatic run_random(int n);
    in_item_t it;
    int       done;
    done = 0;
    while (done < n || !sb.idle()) begin
      it = random_item();
      drive_item(it);
      done++;
    end
  endtask

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    hold_on        = 1'b0;
    sender_gap_pct = 27;
    sink_stall_pct = 63;
    repeat (RESET_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_config(1'b1);
    run_directed();
    run_random(90);
    drain();

    write_config(1'b0);
    sender_gap_pct = 63;
    sink_stall_pct = 27;
    run_random(100);
    drain();

    write_config(1'b1);
    sender_gap_pct = 0;
    sink_stall_pct = 0;
    // long sink hold so the job queue fills and the input stalls
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    join_none
    run_random(80);
    drain();

    write_config(1'b0);
    run_random(33);
    drain();

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/snfcs_pkg.sv
rtl/snfcs_queue.sv
rtl/snfcs_front.sv
rtl/snfcs_back.sv
rtl/spi_nor_flash_command_sequencer.sv
dv/testbench.sv
